// ===== src/ipv4hg_pkg.sv =====
// shared types and constants for the ipv4 header generator
package ipv4hg_pkg;

    localparam int unsigned HDR_WORDS   = 10;
    localparam int unsigned IDX_W       = $clog2(HDR_WORDS);
    localparam int unsigned PSUM_W      = 19;
    localparam int unsigned SUM_W       = 19;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TTL_VALUE   = 8'd64;

    localparam logic [IDX_W-1:0] W_VER_IHL  = IDX_W'(0);
    localparam logic [IDX_W-1:0] W_TOT_LEN  = IDX_W'(1);
    localparam logic [IDX_W-1:0] W_IDENT    = IDX_W'(2);
    localparam logic [IDX_W-1:0] W_FRAG     = IDX_W'(3);
    localparam logic [IDX_W-1:0] W_TTL_PROT = IDX_W'(4);
    localparam logic [IDX_W-1:0] W_CSUM     = IDX_W'(5);
    localparam logic [IDX_W-1:0] W_SRC_HI   = IDX_W'(6);
    localparam logic [IDX_W-1:0] W_SRC_LO   = IDX_W'(7);
    localparam logic [IDX_W-1:0] W_DST_HI   = IDX_W'(8);
    localparam logic [IDX_W-1:0] W_DST_LO   = IDX_W'(9);

    typedef struct packed {
        logic [15:0]       total_len;
        logic [15:0]       ident;
        logic [7:0]        proto;
        logic [31:0]       dst;
        logic [PSUM_W-1:0] psum;
    } hdr_req_t;

endpackage

// ===== src/ipv4hg_req_stage.sv =====
// request register: length clamp, identification stamp, partial checksum sum
module ipv4hg_req_stage
    import ipv4hg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_destination_address,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_payload_length,
    output logic        req_valid,
    input  logic        req_take,
    output hdr_req_t    req
);

    logic        valid_reg;
    logic [15:0] ident_reg;
    hdr_req_t    req_reg;
    hdr_req_t    req_next;
    logic [15:0] plen;
    logic        accept;

    assign s_ready = !valid_reg || req_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        plen = (s_payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : s_payload_length;
        req_next.total_len = plen + HDR_BYTES;
        req_next.ident     = ident_reg;
        req_next.proto     = s_protocol_number;
        req_next.dst       = s_destination_address;
        req_next.psum      = PSUM_W'(req_next.total_len)
                           + PSUM_W'(ident_reg)
                           + PSUM_W'({TTL_VALUE, s_protocol_number})
                           + PSUM_W'(s_destination_address[31:16])
                           + PSUM_W'(s_destination_address[15:0])
                           + PSUM_W'({VER_IHL, 8'h00});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ident_reg <= 16'd0;
        end else begin
            if (accept) begin
                valid_reg <= 1'b1;
                ident_reg <= ident_reg + 16'd1;
            end else if (req_take) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== src/ipv4hg_serializer.sv =====
// checksum finish and ten-word header output register
module ipv4hg_serializer
    import ipv4hg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] source_address,
    input  logic        req_valid,
    output logic        req_take,
    input  hdr_req_t    req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_header_word,
    output logic        m_last_word
);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      total_len_reg;
    logic [15:0]      ident_reg;
    logic [7:0]       proto_reg;
    logic [15:0]      csum_reg;
    logic [31:0]      dst_reg;
    logic [SUM_W-1:0] full_sum;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    logic             last;
    logic             free;

    assign last     = (idx_reg == W_DST_LO);
    assign free     = !busy_reg || (m_ready && last);
    assign req_take = req_valid && free;

    always_comb begin
        full_sum = req.psum
                 + SUM_W'(source_address[31:16])
                 + SUM_W'(source_address[15:0]);
        fold1    = 17'(full_sum[15:0]) + 17'(full_sum[SUM_W-1:16]);
        fold2    = fold1[15:0] + 16'(fold1[16]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= W_VER_IHL;
        end else begin
            if (req_take) begin
                busy_reg <= 1'b1;
                idx_reg  <= W_VER_IHL;
            end else if (busy_reg && m_ready) begin
                if (last) begin
                    busy_reg <= 1'b0;
                    idx_reg  <= W_VER_IHL;
                end else begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            total_len_reg <= req.total_len;
            ident_reg     <= req.ident;
            proto_reg     <= req.proto;
            dst_reg       <= req.dst;
            csum_reg      <= ~fold2;
        end
    end

    always_comb begin
        unique case (idx_reg)
            W_VER_IHL:  m_header_word = {VER_IHL, 8'h00};
            W_TOT_LEN:  m_header_word = total_len_reg;
            W_IDENT:    m_header_word = ident_reg;
            W_FRAG:     m_header_word = 16'h0000;
            W_TTL_PROT: m_header_word = {TTL_VALUE, proto_reg};
            W_CSUM:     m_header_word = csum_reg;
            W_SRC_HI:   m_header_word = source_address[31:16];
            W_SRC_LO:   m_header_word = source_address[15:0];
            W_DST_HI:   m_header_word = dst_reg[31:16];
            W_DST_LO:   m_header_word = dst_reg[15:0];
            default:    m_header_word = 16'h0000;
        endcase
    end

    assign m_valid     = busy_reg;
    assign m_last_word = last;

endmodule

// ===== src/ipv4_header_generator.sv =====
// top level: source address register, request stage and header serializer
//
//  channel  | ports                                   | dir | handshake
//  ---------+-----------------------------------------+-----+----------------
//  request  | s_destination_address, s_protocol_number,| in  | s_valid/s_ready
//           | s_payload_length                        |     |
//  header   | m_header_word, m_last_word              | out | m_valid/m_ready
//  config   | cfg_wr_data (source address)            | in  | cfg_wr_en
//
// each item gives ten header words, one per cycle while m_ready is high, so
// the item rate is set by the 16-bit output port. an accepted item passes
// through the request register and then the output register before its first
// word; the next item is held in the request register and moves to the output
// register in the cycle the last word leaves. synchronous active-low reset
// clears the identification counter, the source address and all valid state.
module ipv4_header_generator
    import ipv4hg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_destination_address,
    input  logic [7:0]  s_protocol_number,
    input  logic [15:0] s_payload_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_header_word,
    output logic        m_last_word
);

    logic [31:0] src_addr_reg;
    logic        req_valid;
    logic        req_take;
    hdr_req_t    req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg <= 32'd0;
        end else if (cfg_wr_en) begin
            src_addr_reg <= cfg_wr_data;
        end
    end

    ipv4hg_req_stage u_req_stage (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_destination_address (s_destination_address),
        .s_protocol_number     (s_protocol_number),
        .s_payload_length      (s_payload_length),
        .req_valid             (req_valid),
        .req_take              (req_take),
        .req                   (req)
    );

    ipv4hg_serializer u_serializer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .source_address (src_addr_reg),
        .req_valid      (req_valid),
        .req_take       (req_take),
        .req            (req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_word  (m_header_word),
        .m_last_word    (m_last_word)
    );

endmodule

// ===== bench/ipv4_header_generator_tb.sv =====
// testbench for the ipv4 header generator: predicts all ten header words per item and checks them
`timescale 1ns / 1ps

module ipv4_header_generator_tb;
    import ipv4hg_pkg::*;

    localparam int CYCLE_LIMIT   = 50_000;
    localparam int LONG_HOLD     = 300;
    localparam int BULK_ITEMS    = 20;
    localparam int RANDOM_ITEMS  = 56;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] plen;
    } ip_request_t;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } header_word_t;

    typedef enum logic [1:0] {PH_DIRECTED, PH_BULK, PH_RANDOM} tb_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_destination_address;
    logic [7:0]  s_protocol_number;
    logic [15:0] s_payload_length;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_header_word;
    logic        m_last_word;

    ip_request_t  pending_requests[$];
    header_word_t header_words[$];
    ip_request_t  next_req;
    header_word_t exp_word;

    logic [31:0] source_copy;
    logic [15:0] ident_copy;
    logic        req_taken;
    logic        idle_free;
    logic        hold_done;
    int          hold_left;
    int          mismatch_count;
    int          cycle_count;
    tb_phase_t   phase;

    ipv4_header_generator DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_wr_data           (cfg_wr_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_destination_address (s_destination_address),
        .s_protocol_number     (s_protocol_number),
        .s_payload_length      (s_payload_length),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_header_word         (m_header_word),
        .m_last_word           (m_last_word)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // expected words of one header, checksum folded with end-around carry
    function automatic void build_header(input ip_request_t req, input logic [31:0] src,
                                         input logic [15:0] ident);
        logic [15:0] w [HDR_WORDS];
        logic [15:0] plen_sat;
        logic [31:0] acc;
        plen_sat = (req.plen > MAX_PAYLOAD) ? MAX_PAYLOAD : req.plen;
        w[W_VER_IHL]  = {VER_IHL, 8'h00};
        w[W_TOT_LEN]  = HDR_BYTES + plen_sat;
        w[W_IDENT]    = ident;
        w[W_FRAG]     = 16'h0000;
        w[W_TTL_PROT] = {TTL_VALUE, req.proto};
        w[W_CSUM]     = 16'h0000;
        w[W_SRC_HI]   = src[31:16];
        w[W_SRC_LO]   = src[15:0];
        w[W_DST_HI]   = req.dst[31:16];
        w[W_DST_LO]   = req.dst[15:0];
        acc = 32'd0;
        for (int i = 0; i < HDR_WORDS; i++) acc += w[i];
        acc = (acc & 32'hFFFF) + (acc >> 16);
        acc = (acc & 32'hFFFF) + (acc >> 16);
        w[W_CSUM] = ~acc[15:0];
        for (int i = 0; i < HDR_WORDS; i++)
            header_words.push_back('{word: w[i], last: (i == HDR_WORDS - 1)});
    endfunction

    function automatic ip_request_t random_request();
        ip_request_t req;
        int pick;
        pick = $urandom_range(0, 99);
        req.dst   = $urandom;
        req.proto = 8'($urandom_range(0, 255));
        if (pick < 60)
            req.plen = 16'($urandom_range(0, 1500));
        else if (pick < 90)
            req.plen = 16'($urandom_range(0, 65535));
        else
            req.plen = 16'($urandom_range(65500, 65535));
        return req;
    endfunction

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || header_words.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_source(input logic [31:0] addr);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        source_copy = addr;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_directed();
        pending_requests.push_back('{dst: 32'h0000_0000, proto: 8'd0,   plen: 16'd0});
        pending_requests.push_back('{dst: 32'hFFFF_FFFF, proto: 8'd255, plen: 16'd65515});
        pending_requests.push_back('{dst: 32'hFFFF_FFFF, proto: 8'd255, plen: 16'd65516});
        pending_requests.push_back('{dst: 32'hAAAA_5555, proto: 8'd6,   plen: 16'd65535});
        pending_requests.push_back('{dst: 32'h5555_AAAA, proto: 8'd17,  plen: 16'd1});
        pending_requests.push_back('{dst: 32'hC0A8_0101, proto: 8'd1,   plen: 16'd1480});
        pending_requests.push_back('{dst: 32'h0A00_0001, proto: 8'h80,  plen: 16'h8000});
        pending_requests.push_back('{dst: 32'hFFFF_0000, proto: 8'h7F,  plen: 16'h7FFF});
        pending_requests.push_back('{dst: 32'h0000_FFFF, proto: 8'hAA,  plen: 16'h5555});
        pending_requests.push_back('{dst: 32'hE000_0001, proto: 8'h55,  plen: 16'hAAAA});
        pending_requests.push_back('{dst: 32'h7FFF_FFFF, proto: 8'd255, plen: 16'd65534});
        pending_requests.push_back('{dst: 32'h8000_0000, proto: 8'd0,   plen: 16'd20});
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (pending_requests.size() != 0 && (idle_free || $urandom_range(0, 99) >= 33)) begin
                next_req = pending_requests.pop_front();
                s_destination_address <= next_req.dst;
                s_protocol_number     <= next_req.proto;
                s_payload_length      <= next_req.plen;
                s_valid               <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // accepted items go through the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            req_taken  <= 1'b0;
            ident_copy <= 16'h0000;
        end else begin
            req_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                build_header('{dst: s_destination_address, proto: s_protocol_number,
                               plen: s_payload_length}, source_copy, ident_copy);
                ident_copy <= ident_copy + 16'd1;
            end
        end
    end

    // receiver, with one long hold-off at the start of the random part
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == PH_RANDOM && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_ready <= idle_free || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (header_words.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected header word %h last %b", m_header_word, m_last_word);
                mismatch_count++;
            end else begin
                exp_word = header_words.pop_front();
                if (m_header_word !== exp_word.word || m_last_word !== exp_word.last) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("header word mismatch: expected %h last %b, got %h last %b",
                                 exp_word.word, exp_word.last, m_header_word, m_last_word);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ipv4_header_generator] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 32'd0;
        s_valid               = 1'b0;
        s_destination_address = 32'd0;
        s_protocol_number     = 8'd0;
        s_payload_length      = 16'd0;
        m_ready               = 1'b0;
        source_copy           = 32'd0;
        idle_free             = 1'b0;
        mismatch_count        = 0;
        cycle_count           = 0;
        phase                 = PH_DIRECTED;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // reset source address first, then all ones
        queue_directed();
        wait_drained();
        write_source(32'hFFFF_FFFF);
        queue_directed();
        wait_drained();

        // back-to-back run with no idling on either side
        write_source($urandom);
        phase     = PH_BULK;
        idle_free = 1'b1;
        for (int i = 0; i < BULK_ITEMS; i++) pending_requests.push_back(random_request());
        wait_drained();
        idle_free = 1'b0;

        phase = PH_RANDOM;
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: write_source(32'hC0A8_0001);
                3: write_source(32'h0000_0000);
                default: write_source($urandom);
            endcase
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                pending_requests.push_back(random_request());
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && header_words.size() == 0)
            $display("[ipv4_header_generator] OK");
        else
            $display("[ipv4_header_generator] ERROR");
        $finish;
    end

endmodule
